/* src/sig_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sig_pkg: shared types and constants of the sector interleave id generator
// Register indexes, field widths, reset values and the control/status
// structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package sig_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int SECTOR_W   = 6;
  localparam int CODE_W     = 4;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_TRACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES      = 2'd2;

  localparam logic [5:0]  RST_SECTORS_PER_TRACK = 6'd18;
  localparam logic [5:0]  RST_INTERLEAVE_STEP   = 6'd1;
  localparam logic [11:0] RST_SECTOR_BYTES      = 12'd512;

  // size code remap: the 1024-byte code folds onto the 768-byte code
  localparam logic [CODE_W-1:0] CODE_FOLD_FROM = 4'd4;
  localparam logic [CODE_W-1:0] CODE_FOLD_TO   = 4'd3;

  typedef struct packed {
    logic load;
    logic place;
    logic scan;
    logic emit;
    logic err;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic wrap;
    logic last_sec;
    logic scan_done;
    logic last_slot;
  } status_t;

endpackage

/* src/sig_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sig_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sig_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/sig_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sig_ctrl: track format sequencer
// Steps through check, placement, free-slot scan and record emission, or gives an error record after a failed check.
// ----------------------------------------------------------------------------
module sig_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sig_pkg::status_t  st,
  output sig_pkg::cmd_t     cmd
);
  import sig_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_ERR   = 7'b0000100,
    S_PLACE = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = st.bad ? S_ERR : S_PLACE;
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        if (st.last_sec) begin
          state_nxt = S_READ;
        end else if (st.wrap) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_PLACE;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = st.last_slot ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* src/sig_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sig_datapath: slot table, position arithmetic and record registers
// Holds the configuration, the occupancy bits and the sector RAM, and
// builds each ID record from the slot read back.
// ----------------------------------------------------------------------------
module sig_datapath #(
  parameter int MAX_SECTORS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sig_pkg::cmd_t                       cmd,
  output sig_pkg::status_t                    st,
  input  logic                                cfg_valid,
  input  logic [sig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sig_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [sig_pkg::BYTE_W-1:0]          in_cylinder,
  input  logic [sig_pkg::BYTE_W-1:0]          in_head,
  output logic                                out_valid,
  output logic [sig_pkg::BYTE_W-1:0]          out_id_cylinder,
  output logic [sig_pkg::BYTE_W-1:0]          out_id_head,
  output logic [sig_pkg::SECTOR_W-1:0]        out_id_sector,
  output logic [sig_pkg::CODE_W-1:0]          out_size_code,
  output logic                                out_last_record,
  output logic                                out_bad_interleave
);
  import sig_pkg::*;

  localparam int CW = $clog2(MAX_SECTORS + 1);
  localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int SW = CW + 1;

  logic [5:0]             spt_r;
  logic [5:0]             step_r;
  logic [11:0]            bytes_r;
  logic [BYTE_W-1:0]      cyl_r;
  logic [BYTE_W-1:0]      head_r;
  logic [CW-1:0]          n_r;
  logic [CW-1:0]          sec_r;
  logic [AW-1:0]          pos_r;
  logic [AW-1:0]          scan_r;
  logic                   phase_r;
  logic [AW-1:0]          k_r;
  logic [MAX_SECTORS-1:0] occ_r;

  logic                   out_valid_r;
  logic [BYTE_W-1:0]      out_cyl_r;
  logic [BYTE_W-1:0]      out_head_r;
  logic [SECTOR_W-1:0]    out_sector_r;
  logic [CODE_W-1:0]      out_code_r;
  logic                   out_last_r;
  logic                   out_bad_r;

  logic [CW-1:0]          n_sat;
  logic [SW-1:0]          pos_sum;
  logic [AW-1:0]          pos_wrapped;
  logic                   scan_free;
  logic                   scan_end;
  logic [CODE_W-1:0]      size_code;
  logic [SECTOR_W-1:0]    ram_rdata;

  always_comb begin
    if (32'(spt_r) > 32'(MAX_SECTORS)) begin
      n_sat = CW'(MAX_SECTORS);
    end else begin
      n_sat = CW'(spt_r);
    end
  end

  // step is below n on every path that uses the sum
  assign pos_sum     = SW'(pos_r) + SW'(step_r);
  assign pos_wrapped = AW'(pos_sum - SW'(n_r));
  assign scan_free   = !occ_r[scan_r];
  assign scan_end    = (SW'(scan_r) + SW'(1) == SW'(n_r));

  assign st.bad       = (step_r == 6'd0) || (32'(step_r) >= 32'(n_r));
  assign st.wrap      = (pos_sum >= SW'(n_r));
  assign st.last_sec  = (sec_r == n_r);
  assign st.scan_done = scan_free || (scan_end && phase_r);
  assign st.last_slot = (SW'(k_r) + SW'(1) == SW'(n_r));

  always_comb begin
    size_code = bytes_r[11:8];
    if (size_code == CODE_FOLD_FROM) begin
      size_code = CODE_FOLD_TO;
    end
  end

  sig_ram #(
    .WIDTH (SECTOR_W),
    .DEPTH (MAX_SECTORS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.place),
    .waddr (pos_r),
    .wdata (SECTOR_W'(sec_r)),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= RST_SECTORS_PER_TRACK;
      step_r  <= RST_INTERLEAVE_STEP;
      bytes_r <= RST_SECTOR_BYTES;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SECTORS_PER_TRACK: spt_r   <= cfg_data[5:0];
        CFG_INTERLEAVE_STEP:   step_r  <= cfg_data[5:0];
        CFG_SECTOR_BYTES:      bytes_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // occupancy bits and the output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.err;
      if (cmd.load) begin
        occ_r <= '0;
      end else if (cmd.place) begin
        occ_r[pos_r] <= 1'b1;
      end
    end
  end

  // placement walk and free-slot scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cyl_r  <= in_cylinder;
      head_r <= in_head;
      n_r    <= n_sat;
      sec_r  <= CW'(1);
      pos_r  <= '0;
      k_r    <= '0;
    end
    if (cmd.place) begin
      sec_r <= sec_r + CW'(1);
      if (st.wrap) begin
        scan_r  <= pos_wrapped;
        phase_r <= 1'b0;
      end else begin
        pos_r <= AW'(pos_sum);
      end
    end
    if (cmd.scan) begin
      if (scan_free) begin
        pos_r <= scan_r;
      end else if (scan_end) begin
        // second pass from slot 0; a full track falls back to slot 0
        if (phase_r) begin
          pos_r <= '0;
        end else begin
          scan_r  <= '0;
          phase_r <= 1'b1;
        end
      end else begin
        scan_r <= scan_r + AW'(1);
      end
    end
    if (cmd.emit) begin
      k_r <= k_r + AW'(1);
    end
  end

  // record register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cyl_r    <= cyl_r;
      out_head_r   <= head_r;
      out_sector_r <= occ_r[k_r] ? ram_rdata : '0;
      out_code_r   <= size_code;
      out_last_r   <= st.last_slot;
      out_bad_r    <= 1'b0;
    end else if (cmd.err) begin
      out_cyl_r    <= '0;
      out_head_r   <= '0;
      out_sector_r <= '0;
      out_code_r   <= '0;
      out_last_r   <= 1'b1;
      out_bad_r    <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_id_cylinder    = out_cyl_r;
  assign out_id_head        = out_head_r;
  assign out_id_sector      = out_sector_r;
  assign out_size_code      = out_code_r;
  assign out_last_record    = out_last_r;
  assign out_bad_interleave = out_bad_r;

endmodule

/* src/sector_interleave_id_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_interleave_id_generator: floppy track format ID record builder
// Places logical sectors in an interleaved slot table and gives the ID
// records of one track in physical slot order.
// ----------------------------------------------------------------------------
// Pulse start while busy is low with the track's cylinder and head. The block
// places sectors 1..N one per cycle while no scan runs; after a wrap past the
// track end, unless that sector was the last, it scans forward one slot per
// cycle for a free slot. It then gives N records, each with a read state
// before its emit state, since each slot is fetched from the slot RAM through
// its registered read port. A bad interleave gives one error record through
// the check and error states. Each record is on the out_ ports for one cycle
// under out_valid and the receiver cannot stall it. Configuration is taken
// every cycle (cfg_ready stays high) and should only change while idle.
// ----------------------------------------------------------------------------
module sector_interleave_id_generator #(
  parameter int MAX_SECTORS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sig_pkg::BYTE_W-1:0]     in_cylinder,
  input  logic [sig_pkg::BYTE_W-1:0]     in_head,
  output logic                           out_valid,
  output logic [sig_pkg::BYTE_W-1:0]     out_id_cylinder,
  output logic [sig_pkg::BYTE_W-1:0]     out_id_head,
  output logic [sig_pkg::SECTOR_W-1:0]   out_id_sector,
  output logic [sig_pkg::CODE_W-1:0]     out_size_code,
  output logic                           out_last_record,
  output logic                           out_bad_interleave,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sig_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sig_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  sig_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  sig_datapath #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cylinder        (in_cylinder),
    .in_head            (in_head),
    .out_valid          (out_valid),
    .out_id_cylinder    (out_id_cylinder),
    .out_id_head        (out_id_head),
    .out_id_sector      (out_id_sector),
    .out_size_code      (out_size_code),
    .out_last_record    (out_last_record),
    .out_bad_interleave (out_bad_interleave)
  );

  // a transfer out only follows a cycle of work on a track
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("record given without a track in progress");

  // the error record is always the final one
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_interleave) |-> out_last_record)
    else $error("bad interleave record not marked last");

  // no record directly follows the last record of a track; the next needs a new start
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_record) |=> !out_valid)
    else $error("record given after the last record");

  // an accepted track keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted track did not raise busy");

endmodule
